// ===== design/mmat_pkg.sv =====
// shared types and constants for the multichannel moving average block
`default_nettype none

package mmat_pkg;

  localparam int unsigned DEF_CHANNELS = 16;
  localparam int unsigned DEF_WINDOW   = 5;

  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned PRICE_W   = 32;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [PRICE_W-1:0]   price;
  } in_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel_out;
    logic [PRICE_W-1:0]   current_price;
    logic [PRICE_W-1:0]   window_average;
    logic                 trend_up;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDCH,
    S_RDHIST,
    S_DIV
  } state_e;

endpackage

`default_nettype wire

// ===== design/multichannel_moving_average_trend.sv =====
// Per-channel moving average of price samples with a rising-trend flag.
// in channel: in_valid_i / in_stall_o carry one beat of {channel, price};
// a channel number at or beyond CHANNELS is taken as channel 0.
// out channel: out_valid_o / out_stall_i carry one beat of
// {channel_out, current_price, window_average, trend_up} per input beat.
// Each channel keeps a running sum, fill count, write slot and last average in
// a state memory, and its last WINDOW samples in a history memory; one sample
// is handled at a time: state read, history read, history write, then division.
// The division by the fill count runs eight quotient bits a cycle. The result
// beat is loaded into the output register when the division is done, and the
// next input beat is taken only once that result has left the division stage.
// The result sits in an output register; while the receiver stalls it holds,
// the next input beat is still taken and processed, and its result waits in
// the division stage until the register frees up.
// Reset clears all channels to empty (no samples, average zero) at once.
`default_nettype none

module multichannel_moving_average_trend import mmat_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS,
  parameter int unsigned WINDOW   = DEF_WINDOW
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned CH_W       = $clog2(CHANNELS);
  localparam int unsigned FILL_W     = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W     = $clog2(WINDOW);
  localparam int unsigned SUM_W      = PRICE_W + $clog2(WINDOW);
  localparam int unsigned HIST_DEPTH = CHANNELS * WINDOW;
  localparam int unsigned HA_W       = $clog2(HIST_DEPTH);
  localparam int unsigned CW_W       = SUM_W + PRICE_W + SLOT_W + FILL_W;

  state_e state_q, state_d;

  logic [CH_W-1:0]    ch_q, ch_d;
  logic [PRICE_W-1:0] price_q, price_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [PRICE_W-1:0] lavg_q, lavg_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               first_q, first_d;
  logic [HA_W-1:0]    haddr_q, haddr_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               in_acc;
  logic [31:0]        ch_ext;
  logic [CH_W-1:0]    ch_map;
  logic [CW_W-1:0]    chan_rd_data;
  logic [CW_W-1:0]    chan_wr_data;
  logic [FILL_W-1:0]  rd_fill;
  logic [SLOT_W-1:0]  rd_slot;
  logic [PRICE_W-1:0] rd_lavg;
  logic [SUM_W-1:0]   rd_sum;
  logic [HA_W-1:0]    hist_addr_rd;
  logic [PRICE_W-1:0] hist_rd_data;
  logic               full;
  logic [SUM_W-1:0]   new_sum;
  logic [FILL_W-1:0]  new_fill;
  logic [SLOT_W-1:0]  next_slot;
  logic               div_start;
  logic               div_done;
  logic [PRICE_W-1:0] quot;
  logic               finish;
  logic               trend;
  logic               hist_rd_en;
  logic               hist_wr_en;

  assign in_acc = in_valid_i && !in_stall_o;
  assign ch_ext = 32'(in_data_i.channel);
  assign ch_map = (ch_ext < CHANNELS) ? ch_ext[CH_W-1:0] : '0;

  assign rd_fill = chan_rd_data[FILL_W-1:0];
  assign rd_slot = chan_rd_data[FILL_W +: SLOT_W];
  assign rd_lavg = chan_rd_data[FILL_W + SLOT_W +: PRICE_W];
  assign rd_sum  = chan_rd_data[FILL_W + SLOT_W + PRICE_W +: SUM_W];

  assign hist_addr_rd = HA_W'(32'(ch_q) * WINDOW + 32'(rd_slot));

  // the overwritten sample leaves the running sum only once the window is full
  assign full      = (fill_q == FILL_W'(WINDOW));
  assign new_sum   = sum_q - (full ? SUM_W'(hist_rd_data) : '0) + SUM_W'(price_q);
  assign new_fill  = full ? fill_q : fill_q + 1'b1;
  assign next_slot = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;

  assign finish = (state_q == S_DIV) && div_done && (!out_valid_q || !out_stall_i);
  assign trend  = first_q || (quot > lavg_q);

  assign chan_wr_data = {sum_q, quot, slot_q, fill_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RDCH;
        end
      end
      S_RDCH: begin
        state_d = S_RDHIST;
      end
      S_RDHIST: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    hist_rd_en = 1'b0;
    hist_wr_en = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
      end
      S_RDCH: begin
        hist_rd_en = 1'b1;
      end
      S_RDHIST: begin
        hist_wr_en = 1'b1;
        div_start  = 1'b1;
      end
      S_DIV: begin
        in_stall_o = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    ch_d        = ch_q;
    price_d     = price_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    lavg_d      = lavg_q;
    sum_d       = sum_q;
    first_d     = first_q;
    haddr_d     = haddr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_d    = ch_map;
          price_d = in_data_i.price;
        end
      end
      S_RDCH: begin
        fill_d  = rd_fill;
        slot_d  = rd_slot;
        lavg_d  = rd_lavg;
        sum_d   = rd_sum;
        first_d = (rd_fill == '0);
        haddr_d = hist_addr_rd;
      end
      S_RDHIST: begin
        sum_d  = new_sum;
        fill_d = new_fill;
        slot_d = next_slot;
      end
      S_DIV: begin
        ch_d = ch_q;
      end
      default: begin
        ch_d = ch_q;
      end
    endcase
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
      out_d = '{channel_out:    CHANNEL_W'(ch_q),
                current_price:  price_q,
                window_average: quot,
                trend_up:       trend};
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    price_q <= price_d;
    fill_q  <= fill_d;
    slot_q  <= slot_d;
    lavg_q  <= lavg_d;
    sum_q   <= sum_d;
    first_q <= first_d;
    haddr_q <= haddr_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  mmat_state_ram #(
    .DEPTH(CHANNELS),
    .WIDTH(CW_W)
  ) u_state_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_acc),
    .rd_addr_i(ch_map),
    .rd_data_o(chan_rd_data),
    .wr_en_i  (finish),
    .wr_addr_i(ch_q),
    .wr_data_i(chan_wr_data)
  );

  mmat_hist_ram #(
    .DEPTH(HIST_DEPTH),
    .WIDTH(PRICE_W)
  ) u_hist_ram (
    .clk_i    (clk_i),
    .rd_en_i  (hist_rd_en),
    .rd_addr_i(hist_addr_rd),
    .rd_data_o(hist_rd_data),
    .wr_en_i  (hist_wr_en),
    .wr_addr_i(haddr_q),
    .wr_data_i(price_q)
  );

  mmat_divider #(
    .SUM_W(SUM_W),
    .DSR_W(FILL_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(new_sum),
    .divisor_i (new_fill),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  a_accept_reads_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_RDCH))
    else $error("accepted beat did not start a state read");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDHIST) |-> (fill_q <= FILL_W'(WINDOW)))
    else $error("fill count beyond window");

  a_wait_for_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) && !div_done) |=> (state_q == S_DIV))
    else $error("left division before quotient was ready");

  a_finish_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("finished item did not reach the output register");

endmodule

`default_nettype wire

// ===== design/mmat_state_ram.sv =====
// per-channel state memory, registered read, entries read as zero until written
`default_nettype none

module mmat_state_ram import mmat_pkg::*; #(
  parameter int unsigned DEPTH = DEF_CHANNELS,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== design/mmat_hist_ram.sv =====
// sample history memory, one write and one registered read port
`default_nettype none

module mmat_hist_ram import mmat_pkg::*; #(
  parameter int unsigned DEPTH = DEF_CHANNELS * DEF_WINDOW,
  parameter int unsigned WIDTH = PRICE_W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/mmat_divider.sv =====
// iterative restoring divider by a small count, eight quotient bits per cycle
`default_nettype none

module mmat_divider import mmat_pkg::*; #(
  parameter int unsigned SUM_W = PRICE_W + 3,
  parameter int unsigned DSR_W = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SUM_W-1:0]   dividend_i,
  input  wire logic [DSR_W-1:0]   divisor_i,
  output logic                    done_o,
  output logic      [PRICE_W-1:0] quotient_o
);

  localparam int unsigned STEP_BITS = 8;
  localparam int unsigned STEPS     = (SUM_W + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned WORK_W    = STEPS * STEP_BITS;
  localparam int unsigned CNT_W     = $clog2(STEPS + 1);

  logic [WORK_W-1:0] work_q, work_d;
  logic [DSR_W:0]    rem_q, rem_d;
  logic [DSR_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    if (start_i) begin
      work_d = WORK_W'(dividend_i);
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = CNT_W'(STEPS);
      run_d  = 1'b1;
    end else if (cnt_q != '0) begin
      for (int i = 0; i < STEP_BITS; i++) begin
        rem_d  = {rem_d[DSR_W-1:0], work_d[WORK_W-1]};
        work_d = {work_d[WORK_W-2:0], 1'b0};
        if (rem_d >= {1'b0, dsr_q}) begin
          rem_d     = rem_d - {1'b0, dsr_q};
          work_d[0] = 1'b1;
        end
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  assign done_o     = run_q && (cnt_q == '0);
  assign quotient_o = work_q[PRICE_W-1:0];

endmodule

`default_nettype wire

// ===== sim/tb_multichannel_moving_average_trend.sv =====
// testbench for the per-channel moving average and trend block
module tb_multichannel_moving_average_trend import mmat_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH        = DEF_CHANNELS;
  localparam int unsigned WIN        = DEF_WINDOW;
  localparam int unsigned RAND_BEATS = 750;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned TAIL       = 30;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  multichannel_moving_average_trend uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state, one row per channel
  logic [31:0] hist_mem [NCH][WIN];
  int unsigned fill_cnt [NCH];
  int unsigned wr_slot  [NCH];
  logic [31:0] prev_avg [NCH];

  in_t         price_beats[$];
  out_t        pending_avgs[$];
  logic [31:0] last_px [NCH];
  logic        in_took = 1'b0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  out_t        want;

  function automatic out_t average_sample(in_t beat);
    out_t        r;
    int unsigned ch;
    int unsigned slot;
    int unsigned cnt;
    int unsigned i;
    logic [63:0] sum;
    logic [63:0] quot;
    logic        up;
    ch = 32'(beat.channel);
    if (ch >= NCH) ch = 0;
    slot = wr_slot[ch];
    hist_mem[ch][slot] = beat.price;
    wr_slot[ch] = (slot + 1 >= WIN) ? 0 : slot + 1;
    cnt = fill_cnt[ch];
    up = (cnt == 0);
    if (cnt < WIN) cnt++;
    sum = '0;
    for (i = 0; i < cnt; i++) sum += hist_mem[ch][i];
    quot = sum / cnt;
    if (!up) up = (quot[31:0] > prev_avg[ch]);
    fill_cnt[ch] = cnt;
    prev_avg[ch] = quot[31:0];
    r.channel_out    = ch[CHANNEL_W-1:0];
    r.current_price  = beat.price;
    r.window_average = quot[31:0];
    r.trend_up       = up;
    return r;
  endfunction

  task automatic add_beat(input int unsigned ch, input logic [31:0] px);
    in_t b;
    b.channel = ch[CHANNEL_W-1:0];
    b.price   = px;
    last_px[ch] = px;
    price_beats.push_back(b);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (price_beats.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= price_beats.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall modes that change over time, plus one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen >= 150) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // beat monitor: check results first, then predict the new input beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_avgs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_data_o);
          errors++;
        end else begin
          want = pending_avgs.pop_front();
          check_field("channel_out", 32'(want.channel_out), 32'(out_data_o.channel_out));
          check_field("current_price", want.current_price, out_data_o.current_price);
          check_field("window_average", want.window_average, out_data_o.window_average);
          check_field("trend_up", 32'(want.trend_up), 32'(out_data_o.trend_up));
        end
      end
      if (in_valid_i && !in_stall_o) pending_avgs.push_back(average_sample(in_data_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no beat moved for %0d cycles", $time, idle_cycles);
        $display("tb_multichannel_moving_average_trend: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned ch;
    int unsigned pick;
    logic [31:0] px;
    for (ch = 0; ch < NCH; ch++) begin
      fill_cnt[ch] = 0;
      wr_slot[ch]  = 0;
      prev_avg[ch] = '0;
      last_px[ch]  = '0;
      for (n = 0; n < WIN; n++) hist_mem[ch][n] = '0;
    end

    // zero price, then an equal average
    add_beat(0, 32'd0);
    add_beat(0, 32'd0);
    // full-scale prices: sum runs past 32 bits, window wraps, then a drop
    for (n = 0; n < 6; n++) add_beat(15, 32'hFFFF_FFFF);
    add_beat(15, 32'd0);
    // steady rise through a wrap, then a fall
    for (n = 1; n <= 6; n++) add_beat(3, 100 * n);
    add_beat(3, 32'd1);
    // truncation of a fractional average
    add_beat(7, 32'd7);
    add_beat(7, 32'd8);
    add_beat(7, 32'd8);

    ch = 0;
    for (n = 0; n < RAND_BEATS; n++) begin
      if ($urandom_range(0, 1) == 0) ch = $urandom_range(0, NCH - 1);
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: px = $urandom;
        4, 5, 6: px = last_px[ch] + $urandom_range(0, 20) - 10;
        7: px = last_px[ch];
        8: px = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
        default: px = $urandom_range(0, 1000);
      endcase
      add_beat(ch, px);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (price_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (errors == 0 && pending_avgs.size() == 0) begin
      $display("tb_multichannel_moving_average_trend: done, clean");
    end else begin
      $display("tb_multichannel_moving_average_trend: done, errors");
    end
    $finish;
  end

endmodule
